FILE: rtl/gbm_pkg.sv
// Shared types, command codes and helpers for the growable bit matrix engine.
package gbm_pkg;

    localparam int CNT_W = 7;
    localparam int IDX_W = 6;

    localparam logic [2:0] CMD_GET       = 3'd0;
    localparam logic [2:0] CMD_SET       = 3'd1;
    localparam logic [2:0] CMD_CLEAR     = 3'd2;
    localparam logic [2:0] CMD_SET_ALL   = 3'd3;
    localparam logic [2:0] CMD_CLEAR_ALL = 3'd4;
    localparam logic [2:0] CMD_FIND_ROW  = 3'd5;
    localparam logic [2:0] CMD_FIND_COL  = 3'd6;
    localparam logic [2:0] CMD_REINIT    = 3'd7;

    localparam logic REG_INITIAL_ROWS = 1'b0;
    localparam logic REG_INITIAL_COLS = 1'b1;

    typedef struct packed {
        logic             bit_val;
        logic             hit;
        logic [IDX_W-1:0] idx;
    } eval_t;

    function automatic logic [CNT_W-1:0] clamp_size(input logic [CNT_W-1:0] v,
                                                    input logic [CNT_W-1:0] limit);
        logic [CNT_W-1:0] r;
        if (v == '0)
            r = CNT_W'(1);
        else if (v > limit)
            r = limit;
        else
            r = v;
        return r;
    endfunction

endpackage

FILE: rtl/gbm_row_mem.sv
// Row store: one write port, one read port with registered read data.
module gbm_row_mem
    import gbm_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64,
    parameter int AW    = 6
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/gbm_row_eval.sv
// Row word evaluation: bit pick, highest-match search and single-bit update.
module gbm_row_eval
    import gbm_pkg::*;
#(
    parameter int MAX_COLS = 64
)
(
    input  logic [MAX_COLS-1:0] word,
    input  logic [IDX_W-1:0]    col,
    input  logic                want,
    input  logic                set_op,
    output eval_t               ev,
    output logic [MAX_COLS-1:0] new_word
);

    localparam int COL_BW = $clog2(MAX_COLS);

    logic [MAX_COLS-1:0] onehot;
    logic [MAX_COLS-1:0] lim_mask;
    logic [MAX_COLS-1:0] cand;
    logic [CNT_W-1:0]    col_p1;

    assign onehot   = MAX_COLS'(1) << col;
    assign new_word = set_op ? (word | onehot) : (word & ~onehot);
    assign col_p1   = {1'b0, col} + CNT_W'(1);
    assign lim_mask = ~({MAX_COLS{1'b1}} << col_p1);
    assign cand     = (want ? word : ~word) & lim_mask;

    always_comb
    begin
        ev.bit_val = word[col[COL_BW-1:0]];
        ev.hit     = 1'b0;
        ev.idx     = '0;
        for (int i = 0; i < MAX_COLS; i++)
        begin
            if (cand[i])
            begin
                ev.hit = 1'b1;
                ev.idx = IDX_W'(i);
            end
        end
    end

endmodule

FILE: rtl/growable_bit_matrix_engine.sv
// Top level: command sequencer, size registers and result register around the row store.
// Get, set, clear and find in row: the row read on accept is evaluated in S_EVAL.
// Find in column: S_COL reads from row_index down until a match; one row read a cycle.
// Set all, clear all, reinit: rows 0 to row count - 1 are swept; one row write a cycle.
// After reset all min(MAX_ROWS, 64) rows of the row store are cleared with busy high.
// One command at a time; done pulses for one cycle and the receiver cannot stall.
module growable_bit_matrix_engine
    import gbm_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [2:0]       command,
    input  logic [IDX_W-1:0] row_index,
    input  logic [IDX_W-1:0] col_index,
    input  logic             find_value,
    output logic             done,
    output logic             bit_out,
    output logic             found,
    output logic [IDX_W-1:0] found_index,
    output logic             status,
    output logic [CNT_W-1:0] rows_now,
    output logic [CNT_W-1:0] cols_now,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CNT_W-1:0] cfg_wdata
);

    localparam int ROW_LIMIT = (MAX_ROWS < 64) ? MAX_ROWS : 64;
    localparam int ROW_AW    = $clog2(ROW_LIMIT);
    localparam logic [CNT_W-1:0] ROW_LIMIT_W = CNT_W'(ROW_LIMIT);
    localparam logic [CNT_W-1:0] COL_LIMIT_W = CNT_W'(MAX_COLS);
    localparam logic [ROW_AW-1:0] LAST_ROW   = ROW_AW'(ROW_LIMIT - 1);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_COL   = 3'd3;
    localparam logic [2:0] S_SWEEP = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [2:0]          cmd_reg;
    logic [IDX_W-1:0]    row_reg, col_reg;
    logic                want_reg;
    logic [ROW_AW-1:0]   ptr_reg, ptr_next;
    logic [ROW_AW-1:0]   tag_reg, tag_next;
    logic                pend_reg, pend_next;
    logic                issued_reg, issued_next;
    logic [CNT_W-1:0]    row_count_reg, row_count_next;
    logic [CNT_W-1:0]    col_count_reg, col_count_next;
    logic [CNT_W-1:0]    init_rows_reg, init_cols_reg;
    logic                done_reg, done_next;
    logic                bit_reg, bit_next;
    logic                found_reg, found_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                status_reg, status_next;

    logic                accept;
    logic                in_range;
    logic                storable;
    logic [CNT_W-1:0]    row_p1, col_p1;
    logic [MAX_COLS-1:0] full_mask;

    logic                wr_en;
    logic [ROW_AW-1:0]   wr_addr;
    logic [MAX_COLS-1:0] wr_data;
    logic                rd_en;
    logic [ROW_AW-1:0]   rd_addr;
    logic [MAX_COLS-1:0] rd_data;
    logic [MAX_COLS-1:0] new_word;
    eval_t               ev;

    gbm_row_mem #(
        .DEPTH (ROW_LIMIT),
        .WIDTH (MAX_COLS),
        .AW    (ROW_AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gbm_row_eval #(
        .MAX_COLS (MAX_COLS)
    ) u_eval (
        .word     (rd_data),
        .col      (col_reg),
        .want     (want_reg),
        .set_op   (cmd_reg == CMD_SET),
        .ev       (ev),
        .new_word (new_word)
    );

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign row_p1    = {1'b0, row_reg} + CNT_W'(1);
    assign col_p1    = {1'b0, col_reg} + CNT_W'(1);
    assign in_range  = ({1'b0, row_reg} < row_count_reg) && ({1'b0, col_reg} < col_count_reg);
    assign storable  = ({1'b0, row_reg} < ROW_LIMIT_W) && ({1'b0, col_reg} < COL_LIMIT_W);
    assign full_mask = ~({MAX_COLS{1'b1}} << col_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_rows_reg <= CNT_W'(1);
            init_cols_reg <= CNT_W'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_INITIAL_ROWS)
            begin
                init_rows_reg <= cfg_wdata;
            end
            if (cfg_index == REG_INITIAL_COLS)
            begin
                init_cols_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            row_reg  <= row_index;
            col_reg  <= col_index;
            want_reg <= find_value;
        end
        tag_reg <= tag_next;
        bit_reg <= bit_next;
        idx_reg <= idx_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        tag_next       = tag_reg;
        pend_next      = 1'b0;
        issued_next    = issued_reg;
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        done_next      = 1'b0;
        bit_next       = bit_reg;
        found_next     = found_reg;
        idx_next       = idx_reg;
        status_next    = status_reg;
        wr_en          = 1'b0;
        wr_addr        = ptr_reg;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = ptr_reg;

        case (state_reg)
            S_INIT:
            begin
                wr_en = 1'b1;
                if (ptr_reg == LAST_ROW)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + ROW_AW'(1);
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    rd_en   = 1'b1;
                    rd_addr = row_index[ROW_AW-1:0];
                    ptr_next = '0;
                    if (command == CMD_SET_ALL || command == CMD_CLEAR_ALL ||
                        command == CMD_REINIT)
                    begin
                        state_next = S_SWEEP;
                    end
                    else
                    begin
                        state_next = S_EVAL;
                    end
                end
            end
            S_EVAL:
            begin
                state_next  = S_IDLE;
                done_next   = 1'b1;
                bit_next    = 1'b0;
                found_next  = 1'b0;
                idx_next    = '0;
                status_next = 1'b0;
                case (cmd_reg)
                    CMD_GET:
                    begin
                        if (in_range)
                        begin
                            bit_next = ev.bit_val;
                        end
                        else
                        begin
                            status_next = 1'b1;
                        end
                    end
                    CMD_SET, CMD_CLEAR:
                    begin
                        if (storable)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = row_reg[ROW_AW-1:0];
                            wr_data = new_word;
                            if (row_p1 > row_count_reg)
                            begin
                                row_count_next = row_p1;
                            end
                            if (col_p1 > col_count_reg)
                            begin
                                col_count_next = col_p1;
                            end
                        end
                    end
                    CMD_FIND_ROW:
                    begin
                        if (in_range)
                        begin
                            found_next = ev.hit;
                            idx_next   = ev.idx;
                        end
                        else
                        begin
                            status_next = 1'b1;
                        end
                    end
                    CMD_FIND_COL:
                    begin
                        if (in_range)
                        begin
                            state_next  = S_COL;
                            done_next   = 1'b0;
                            ptr_next    = row_reg[ROW_AW-1:0];
                            issued_next = 1'b0;
                        end
                        else
                        begin
                            status_next = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_COL:
            begin
                if (!issued_reg)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    tag_next  = ptr_reg;
                    if (ptr_reg == '0)
                    begin
                        issued_next = 1'b1;
                    end
                    else
                    begin
                        ptr_next = ptr_reg - ROW_AW'(1);
                    end
                end
                if (pend_reg)
                begin
                    if (ev.bit_val == want_reg)
                    begin
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                        found_next = 1'b1;
                        idx_next   = IDX_W'(tag_reg);
                        pend_next  = 1'b0;
                    end
                    else if (tag_reg == '0)
                    begin
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                        pend_next  = 1'b0;
                    end
                end
            end
            S_SWEEP:
            begin
                wr_en   = 1'b1;
                wr_data = (cmd_reg == CMD_SET_ALL) ? full_mask : '0;
                if ((CNT_W'(ptr_reg) + CNT_W'(1)) >= row_count_reg)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    bit_next    = 1'b0;
                    found_next  = 1'b0;
                    idx_next    = '0;
                    status_next = 1'b0;
                    if (cmd_reg == CMD_REINIT)
                    begin
                        row_count_next = clamp_size(init_rows_reg, ROW_LIMIT_W);
                        col_count_next = clamp_size(init_cols_reg, COL_LIMIT_W);
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + ROW_AW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            issued_reg    <= 1'b0;
            row_count_reg <= CNT_W'(1);
            col_count_reg <= CNT_W'(1);
            done_reg      <= 1'b0;
            found_reg     <= 1'b0;
            status_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            issued_reg    <= issued_next;
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            done_reg      <= done_next;
            found_reg     <= found_next;
            status_reg    <= status_next;
        end
    end

    assign done        = done_reg;
    assign bit_out     = bit_reg;
    assign found       = found_reg;
    assign found_index = idx_reg;
    assign status      = status_reg;
    assign rows_now    = row_count_reg;
    assign cols_now    = col_count_reg;

`ifndef NO_ASSERTIONS
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) != S_IDLE && $past(state_reg) != S_INIT)
        else $error("done without a command in flight");

    a_rows_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        row_count_reg >= CNT_W'(1) && row_count_reg <= ROW_LIMIT_W)
        else $error("row count out of bounds");

    a_cols_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        col_count_reg >= CNT_W'(1) && col_count_reg <= COL_LIMIT_W)
        else $error("column count out of bounds");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !wr_en)
        else $error("row store written while idle");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && found_reg |-> !status_reg && !bit_reg)
        else $error("found reported with error status");
`endif

endmodule

FILE: bench/growable_bit_matrix_engine_test.sv
// Self-checking bench for the growable bit matrix engine: directed and random commands.
module growable_bit_matrix_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gbm_pkg::*;

    localparam int MATRIX_DIM = 64;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASE_COUNT = 6;
    localparam int PHASE_ITEMS = 100;

    typedef struct packed {
        logic             bit_out;
        logic             found;
        logic [IDX_W-1:0] found_index;
        logic             status;
        logic [CNT_W-1:0] rows_now;
        logic [CNT_W-1:0] cols_now;
    } matrix_result_t;

    class matrix_scoreboard;
        logic [MATRIX_DIM-1:0] cell_rows [MATRIX_DIM];
        logic [CNT_W-1:0]      row_count;
        logic [CNT_W-1:0]      col_count;
        logic [CNT_W-1:0]      init_rows;
        logic [CNT_W-1:0]      init_cols;
        matrix_result_t        pending_results [$];
        int unsigned           mismatches;

        function new();
            foreach (cell_rows[i])
                cell_rows[i] = '0;
            row_count  = CNT_W'(1);
            col_count  = CNT_W'(1);
            init_rows  = CNT_W'(1);
            init_cols  = CNT_W'(1);
            mismatches = 0;
        endfunction

        function logic [CNT_W-1:0] fit_size(logic [CNT_W-1:0] v);
            if (v == '0)
                return CNT_W'(1);
            if (v > CNT_W'(MATRIX_DIM))
                return CNT_W'(MATRIX_DIM);
            return v;
        endfunction

        function void note_register(logic idx, logic [CNT_W-1:0] value);
            if (idx == REG_INITIAL_ROWS)
                init_rows = value;
            else
                init_cols = value;
        endfunction

        function matrix_result_t predict_command(logic [2:0] cmd, logic [IDX_W-1:0] r,
                                                 logic [IDX_W-1:0] c, logic want);
            matrix_result_t        res;
            logic [MATRIX_DIM-1:0] fill;
            logic                  in_area;
            res     = '0;
            in_area = (CNT_W'(r) < row_count) && (CNT_W'(c) < col_count);
            case (cmd)
                CMD_GET:
                    if (in_area)
                        res.bit_out = cell_rows[r][c];
                    else
                        res.status = 1'b1;
                CMD_SET, CMD_CLEAR:
                begin
                    if (CNT_W'(r) + CNT_W'(1) > row_count)
                        row_count = CNT_W'(r) + CNT_W'(1);
                    if (CNT_W'(c) + CNT_W'(1) > col_count)
                        col_count = CNT_W'(c) + CNT_W'(1);
                    cell_rows[r][c] = (cmd == CMD_SET);
                end
                CMD_SET_ALL:
                begin
                    if (col_count >= CNT_W'(MATRIX_DIM))
                        fill = '1;
                    else
                        fill = (MATRIX_DIM'(1) << col_count) - MATRIX_DIM'(1);
                    foreach (cell_rows[i])
                        cell_rows[i] = (i < int'(row_count)) ? fill : '0;
                end
                CMD_CLEAR_ALL:
                    foreach (cell_rows[i])
                        cell_rows[i] = '0;
                CMD_FIND_ROW:
                    if (!in_area)
                        res.status = 1'b1;
                    else
                        for (int i = int'(c); i >= 0 && !res.found; i--)
                            if (cell_rows[r][i] == want)
                            begin
                                res.found       = 1'b1;
                                res.found_index = IDX_W'(i);
                            end
                CMD_FIND_COL:
                    if (!in_area)
                        res.status = 1'b1;
                    else
                        for (int i = int'(r); i >= 0 && !res.found; i--)
                            if (cell_rows[i][c] == want)
                            begin
                                res.found       = 1'b1;
                                res.found_index = IDX_W'(i);
                            end
                default:
                begin
                    foreach (cell_rows[i])
                        cell_rows[i] = '0;
                    row_count = fit_size(init_rows);
                    col_count = fit_size(init_cols);
                end
            endcase
            res.rows_now = row_count;
            res.cols_now = col_count;
            return res;
        endfunction

        function void note_command(logic [2:0] cmd, logic [IDX_W-1:0] r,
                                   logic [IDX_W-1:0] c, logic want);
            pending_results.push_back(predict_command(cmd, r, c, want));
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(matrix_result_t seen);
            matrix_result_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with nothing outstanding");
                return;
            end
            want = pending_results.pop_front();
            if (seen.bit_out !== want.bit_out)
                report_mismatch($sformatf("bit_out %b, expected %b", seen.bit_out, want.bit_out));
            if (seen.found !== want.found)
                report_mismatch($sformatf("found %b, expected %b", seen.found, want.found));
            if (seen.found_index !== want.found_index)
                report_mismatch($sformatf("found_index %0d, expected %0d",
                                          seen.found_index, want.found_index));
            if (seen.status !== want.status)
                report_mismatch($sformatf("status %b, expected %b", seen.status, want.status));
            if (seen.rows_now !== want.rows_now)
                report_mismatch($sformatf("rows_now %0d, expected %0d",
                                          seen.rows_now, want.rows_now));
            if (seen.cols_now !== want.cols_now)
                report_mismatch($sformatf("cols_now %0d, expected %0d",
                                          seen.cols_now, want.cols_now));
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [2:0]       command;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
    logic             find_value;
    logic             done;
    logic             bit_out;
    logic             found;
    logic [IDX_W-1:0] found_index;
    logic             status;
    logic [CNT_W-1:0] rows_now;
    logic [CNT_W-1:0] cols_now;
    logic             cfg_we;
    logic             cfg_index;
    logic [CNT_W-1:0] cfg_wdata;

    matrix_scoreboard sb = new();
    int unsigned      stalled_cycles;

    growable_bit_matrix_engine dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .row_index   (row_index),
        .col_index   (col_index),
        .find_value  (find_value),
        .done        (done),
        .bit_out     (bit_out),
        .found       (found),
        .found_index (found_index),
        .status      (status),
        .rows_now    (rows_now),
        .cols_now    (cols_now),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    initial
        clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result({bit_out, found, found_index, status, rows_now, cols_now});
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic hold_idle(int unsigned cycles);
        start = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic issue(logic [2:0] cmd, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c, logic want);
        logic accepted;
        start      = 1'b1;
        command    = cmd;
        row_index  = r;
        col_index  = c;
        find_value = want;
        accepted   = 1'b0;
        while (!accepted)
        begin
            @(posedge clk);
            accepted = !busy;
        end
        sb.note_command(cmd, r, c, want);
        @(negedge clk);
    endtask

    task automatic write_register(logic idx, logic [CNT_W-1:0] value);
        start = 1'b0;
        while (sb.pending_results.size() != 0 || busy)
            @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.note_register(idx, value);
    endtask

    function automatic logic [IDX_W-1:0] pick_index(logic [CNT_W-1:0] size);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return IDX_W'($urandom_range(0, int'(size) - 1));
        return IDX_W'($urandom_range(0, MATRIX_DIM - 1));
    endfunction

    task automatic random_item();
        int unsigned pick;
        logic [2:0]  cmd;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            cmd = CMD_GET;
        else if (pick < 38)
            cmd = CMD_SET;
        else if (pick < 48)
            cmd = CMD_CLEAR;
        else if (pick < 53)
            cmd = CMD_SET_ALL;
        else if (pick < 57)
            cmd = CMD_CLEAR_ALL;
        else if (pick < 72)
            cmd = CMD_FIND_ROW;
        else if (pick < 87)
            cmd = CMD_FIND_COL;
        else if (pick < 92)
            cmd = CMD_REINIT;
        else
            cmd = 3'($urandom_range(0, 7));
        issue(cmd, pick_index(sb.row_count), pick_index(sb.col_count),
              1'($urandom_range(0, 1)));
    endtask

    function automatic logic [CNT_W-1:0] pick_size(int unsigned phase, logic for_rows);
        logic [CNT_W-1:0] edges [4] = '{CNT_W'(1), CNT_W'(64), CNT_W'(0), CNT_W'(127)};
        if (phase < 4)
            return for_rows ? edges[phase] : edges[3 - phase];
        if ($urandom_range(0, 3) == 0)
            return CNT_W'($urandom_range(0, 127));
        return CNT_W'($urandom_range(1, 64));
    endfunction

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        command    = CMD_GET;
        row_index  = '0;
        col_index  = '0;
        find_value = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_INITIAL_ROWS;
        cfg_wdata  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_register(REG_INITIAL_ROWS, CNT_W'(0));
        write_register(REG_INITIAL_COLS, CNT_W'(127));
        issue(CMD_GET, 6'd0, 6'd0, 1'b0);
        issue(CMD_GET, 6'd1, 6'd0, 1'b0);
        issue(CMD_FIND_ROW, 6'd0, 6'd1, 1'b0);
        issue(CMD_FIND_COL, 6'd1, 6'd0, 1'b1);
        issue(CMD_FIND_ROW, 6'd0, 6'd0, 1'b1);
        issue(CMD_SET, 6'd63, 6'd63, 1'b0);
        issue(CMD_GET, 6'd63, 6'd63, 1'b1);
        issue(CMD_FIND_COL, 6'd63, 6'd63, 1'b1);
        issue(CMD_FIND_ROW, 6'd63, 6'd62, 1'b1);
        issue(CMD_CLEAR, 6'd63, 6'd63, 1'b0);
        issue(CMD_SET_ALL, 6'd0, 6'd0, 1'b0);
        issue(CMD_FIND_ROW, 6'd17, 6'd63, 1'b0);
        issue(CMD_FIND_ROW, 6'd17, 6'd40, 1'b1);
        issue(CMD_CLEAR, 6'd0, 6'd0, 1'b1);
        issue(CMD_FIND_COL, 6'd63, 6'd0, 1'b0);
        issue(CMD_CLEAR_ALL, 6'd63, 6'd63, 1'b1);
        issue(CMD_FIND_COL, 6'd63, 6'd5, 1'b1);
        issue(CMD_REINIT, 6'd0, 6'd0, 1'b0);
        issue(CMD_GET, 6'd0, 6'd63, 1'b0);
        issue(CMD_GET, 6'd1, 6'd0, 1'b0);
        issue(CMD_SET, 6'd5, 6'd0, 1'b1);
        issue(CMD_FIND_COL, 6'd5, 6'd0, 1'b1);
        write_register(REG_INITIAL_ROWS, CNT_W'(127));
        write_register(REG_INITIAL_COLS, CNT_W'(0));
        issue(CMD_REINIT, 6'd63, 6'd63, 1'b1);
        issue(CMD_SET_ALL, 6'd0, 6'd0, 1'b0);
        issue(CMD_GET, 6'd63, 6'd0, 1'b0);
        issue(CMD_FIND_ROW, 6'd63, 6'd0, 1'b0);

        for (int unsigned phase = 0; phase < PHASE_COUNT; phase++)
        begin
            write_register(REG_INITIAL_ROWS, pick_size(phase, 1'b1));
            write_register(REG_INITIAL_COLS, pick_size(phase, 1'b0));
            issue(CMD_REINIT, '0, '0, 1'b0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase != 2 && $urandom_range(0, 99) < 6)
                    hold_idle($urandom_range(1, 5));
                random_item();
            end
        end
        start = 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending_results.size() != 0)
            sb.report_mismatch("results still outstanding at end of run");
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: growable_bit_matrix_engine.f
rtl/gbm_pkg.sv
rtl/gbm_row_mem.sv
rtl/gbm_row_eval.sv
rtl/growable_bit_matrix_engine.sv
bench/growable_bit_matrix_engine_test.sv
